// ===== design/ppd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the pinhole projection unit
// no dependencies; imported by every module of the block

package ppd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_CFG        = 8;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_SEL_W      = $clog2(NUM_CFG);

    // divider: one quotient bit in the setup stage, the rest two bits a stage
    localparam int DIV_STEPS           = 30;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;
    localparam int QUO_W               = DIV_STEPS + 1;

    typedef logic signed [31:0] word_t;

    localparam word_t ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [CFG_SEL_W-1:0] {
        CFG_FOCAL_X   = 3'd0,
        CFG_FOCAL_Y   = 3'd1,
        CFG_PRINC_X   = 3'd2,
        CFG_PRINC_Y   = 3'd3,
        CFG_RADIAL_K1 = 3'd4,
        CFG_RADIAL_K2 = 3'd5,
        CFG_TANG_P1   = 3'd6,
        CFG_TANG_P2   = 3'd7
    } cfg_idx_t;

    localparam word_t CFG_RESET [NUM_CFG] = '{
        32'sd117964800, 32'sd117964800, 32'sd125829120, 32'sd70778880,
        -32'sd21474836, 32'sd3221225, 32'sd214748, -32'sd107374
    };

    // camera intrinsics and lens terms as seen by the datapath
    typedef struct packed {
        word_t fx;
        word_t fy;
        word_t cx;
        word_t cy;
        word_t k1;
        word_t k2;
        word_t p1;
        word_t p2;
    } ppd_cfg_t;

    // control that travels with every pipeline slot
    typedef struct packed {
        logic valid;
        logic sat;
        logic zero;
    } ppd_ctl_t;

    // floor(a * b / 2^30) of two Q2.30 words
    function automatic logic signed [33:0] mul_q30(input word_t a, input word_t b);
        logic signed [63:0] prod;
        prod = a * b;
        return prod[63:30];
    endfunction

endpackage

// ===== design/ppd_rotate.sv =====
`timescale 1ns / 1ps
// pose stages: quaternion products, rotation matrix, matrix times offset
// depends on ppd_pkg

module ppd_rotate
    import ppd_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ppd_ctl_t             in_ctl,
    input  word_t                rot_w,
    input  word_t                rot_x,
    input  word_t                rot_y,
    input  word_t                rot_z,
    input  word_t                centre_x,
    input  word_t                centre_y,
    input  word_t                centre_z,
    input  word_t                world_x,
    input  word_t                world_y,
    input  word_t                world_z,
    output ppd_ctl_t             out_ctl,
    output logic signed [DW-1:0] p_x,
    output logic signed [DW-1:0] p_y,
    output logic signed [DW-1:0] p_z
);

    // stage 1: quaternion products and offset
    logic signed [32:0]   diff [3];
    logic signed [DW-1:0] d_next [3];
    logic [2:0]           d_ov;
    logic signed [33:0]   qp_next [9];
    logic signed [33:0]   qp_reg [9];
    logic signed [DW-1:0] d_reg [3];
    ppd_ctl_t             ctl1_next, ctl1_reg;

    always_comb
    begin
        diff[0] = 33'(world_x) - 33'(centre_x);
        diff[1] = 33'(world_y) - 33'(centre_y);
        diff[2] = 33'(world_z) - 33'(centre_z);
        // xx yy zz xy xz yz wx wy wz
        qp_next[0] = mul_q30(rot_x, rot_x);
        qp_next[1] = mul_q30(rot_y, rot_y);
        qp_next[2] = mul_q30(rot_z, rot_z);
        qp_next[3] = mul_q30(rot_x, rot_y);
        qp_next[4] = mul_q30(rot_x, rot_z);
        qp_next[5] = mul_q30(rot_y, rot_z);
        qp_next[6] = mul_q30(rot_w, rot_x);
        qp_next[7] = mul_q30(rot_w, rot_y);
        qp_next[8] = mul_q30(rot_w, rot_z);
    end

    // offset clamp to the datapath width
    generate
        if (DW >= 33)
        begin : g_wide
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_next[i] = DW'(diff[i]);
                    d_ov[i]   = 1'b0;
                end
            end
        end
        else
        begin : g_narrow
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_ov[i] = !((&diff[i][32:DW-1]) || !(|diff[i][32:DW-1]));
                    d_next[i] = d_ov[i] ? {diff[i][32], {(DW-1){~diff[i][32]}}}
                                        : diff[i][DW-1:0];
                end
            end
        end
    endgenerate

    always_comb
    begin
        ctl1_next     = in_ctl;
        ctl1_next.sat = in_ctl.sat | (|d_ov);
    end

    // stage 2: rotation matrix entries, clamped to Q2.30
    logic signed [36:0] m_raw [9];
    word_t              m_next [9];
    logic [8:0]         m_ov;
    word_t              m_reg [9];
    logic signed [DW-1:0] d2_reg [3];
    ppd_ctl_t           ctl2_next, ctl2_reg;

    always_comb
    begin
        m_raw[0] = 37'(ONE_Q30) - ((37'(qp_reg[1]) + 37'(qp_reg[2])) <<< 1);
        m_raw[1] = (37'(qp_reg[3]) - 37'(qp_reg[8])) <<< 1;
        m_raw[2] = (37'(qp_reg[4]) + 37'(qp_reg[7])) <<< 1;
        m_raw[3] = (37'(qp_reg[3]) + 37'(qp_reg[8])) <<< 1;
        m_raw[4] = 37'(ONE_Q30) - ((37'(qp_reg[0]) + 37'(qp_reg[2])) <<< 1);
        m_raw[5] = (37'(qp_reg[5]) - 37'(qp_reg[6])) <<< 1;
        m_raw[6] = (37'(qp_reg[4]) - 37'(qp_reg[7])) <<< 1;
        m_raw[7] = (37'(qp_reg[5]) + 37'(qp_reg[6])) <<< 1;
        m_raw[8] = 37'(ONE_Q30) - ((37'(qp_reg[0]) + 37'(qp_reg[1])) <<< 1);
        for (int i = 0; i < 9; i++)
        begin
            m_ov[i]   = !((&m_raw[i][36:31]) || !(|m_raw[i][36:31]));
            m_next[i] = m_ov[i] ? {m_raw[i][36], {31{~m_raw[i][36]}}} : m_raw[i][31:0];
        end
        ctl2_next     = ctl1_reg;
        ctl2_next.sat = ctl1_reg.sat | (|m_ov);
    end

    // stage 3: matrix times offset, nine products
    logic signed [DW+31:0] prod;
    logic signed [DW+1:0]  md_next [9];
    logic signed [DW+1:0]  md_reg [9];
    ppd_ctl_t              ctl3_reg;

    always_comb
    begin
        prod = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod            = m_reg[3*r+c] * d2_reg[c];
                md_next[3*r+c]  = prod[DW+31:30];
            end
        end
    end

    // stage 4: row sums, clamped to the datapath width
    logic signed [DW+3:0] row_sum [3];
    logic signed [DW-1:0] p_next [3];
    logic [2:0]           p_ov;
    logic signed [DW-1:0] p_reg [3];
    ppd_ctl_t             ctl4_next, ctl4_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = (DW+4)'(md_reg[3*r]) + (DW+4)'(md_reg[3*r+1])
                       + (DW+4)'(md_reg[3*r+2]);
            p_ov[r]    = !((&row_sum[r][DW+3:DW-1]) || !(|row_sum[r][DW+3:DW-1]));
            p_next[r]  = p_ov[r] ? {row_sum[r][DW+3], {(DW-1){~row_sum[r][DW+3]}}}
                                 : row_sum[r][DW-1:0];
        end
        ctl4_next     = ctl3_reg;
        ctl4_next.sat = ctl3_reg.sat | (|p_ov);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl4_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qp_reg <= qp_next;
            d_reg  <= d_next;
            m_reg  <= m_next;
            d2_reg <= d_reg;
            md_reg <= md_next;
            p_reg  <= p_next;
        end
    end

    assign out_ctl = ctl4_reg;
    assign p_x     = p_reg[0];
    assign p_y     = p_reg[1];
    assign p_z     = p_reg[2];

endmodule

// ===== design/ppd_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider for the perspective divide, two lanes, shared divisor
// depends on ppd_pkg

module ppd_div
    import ppd_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  ppd_ctl_t             in_ctl,
    input  logic signed [DW-1:0] p_x,
    input  logic signed [DW-1:0] p_y,
    input  logic signed [DW-1:0] p_z,
    output ppd_ctl_t             out_ctl,
    output word_t                norm_x,
    output word_t                norm_y
);

    localparam int NS = DIV_STAGES;

    logic [DW-1:0]    ud_reg   [0:NS];
    logic [DW-1:0]    ud_next  [0:NS];
    logic [DW-1:0]    rem_reg  [0:NS][0:1];
    logic [DW-1:0]    rem_next [0:NS][0:1];
    logic [QUO_W-1:0] quo_reg  [0:NS][0:1];
    logic [QUO_W-1:0] quo_next [0:NS][0:1];
    logic [1:0]       ovf_reg  [0:NS];
    logic [1:0]       ovf_next [0:NS];
    logic [1:0]       neg_reg  [0:NS];
    logic [1:0]       neg_next [0:NS];
    logic [NS:0]      vld_reg, vld_next;
    logic [NS:0]      sat_reg, sat_next;
    logic [NS:0]      zero_reg, zero_next;

    logic signed [DW-1:0] num [0:1];
    logic [DW-1:0]        un;
    logic [DW-1:0]        ud0;
    logic [DW-1:0]        rr;
    logic [DW:0]          r2;
    logic [QUO_W-1:0]     qq;
    logic                 q0;

    assign num[0] = p_x;
    assign num[1] = p_y;

    // setup stage, then two quotient bits per stage
    always_comb
    begin
        ud0 = p_z[DW-1] ? -p_z : p_z;
        un  = '0;
        rr  = '0;
        r2  = '0;
        qq  = '0;
        q0  = 1'b0;
        ud_next[0]   = ud0;
        vld_next[0]  = in_ctl.valid;
        zero_next[0] = (p_z == '0);
        for (int l = 0; l < 2; l++)
        begin
            un = num[l][DW-1] ? -num[l] : num[l];
            q0 = (un >= ud0);
            ovf_next[0][l]  = ({1'b0, un} >= {ud0, 1'b0});
            neg_next[0][l]  = num[l][DW-1] ^ p_z[DW-1];
            rem_next[0][l]  = q0 ? (un - ud0) : un;
            quo_next[0][l]  = QUO_W'(q0);
        end
        sat_next[0] = in_ctl.sat | (|ovf_next[0]);

        for (int s = 1; s <= NS; s++)
        begin
            ud_next[s]   = ud_reg[s-1];
            vld_next[s]  = vld_reg[s-1];
            sat_next[s]  = sat_reg[s-1];
            zero_next[s] = zero_reg[s-1];
            ovf_next[s]  = ovf_reg[s-1];
            neg_next[s]  = neg_reg[s-1];
            for (int l = 0; l < 2; l++)
            begin
                rr = rem_reg[s-1][l];
                qq = quo_reg[s-1][l];
                for (int k = 0; k < DIV_STEPS_PER_STAGE; k++)
                begin
                    r2 = {rr, 1'b0};
                    if (r2 >= {1'b0, ud_reg[s-1]})
                    begin
                        r2 = r2 - {1'b0, ud_reg[s-1]};
                        qq = {qq[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        qq = {qq[QUO_W-2:0], 1'b0};
                    end
                    rr = r2[DW-1:0];
                end
                rem_next[s][l] = rr;
                quo_next[s][l] = qq;
            end
        end
    end

    // sign and overflow clamp of the quotients
    word_t    res_next [0:1];
    word_t    res_reg  [0:1];
    ppd_ctl_t ctl_out_reg;
    logic [QUO_W-1:0] qsel;

    always_comb
    begin
        qsel = '0;
        for (int l = 0; l < 2; l++)
        begin
            qsel        = ovf_reg[NS][l] ? {QUO_W{1'b1}} : quo_reg[NS][l];
            res_next[l] = neg_reg[NS][l] ? -word_t'({1'b0, qsel}) : word_t'({1'b0, qsel});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            ctl_out_reg <= '0;
        end
        else if (en)
        begin
            vld_reg     <= vld_next;
            ctl_out_reg <= '{valid: vld_reg[NS], sat: sat_reg[NS], zero: zero_reg[NS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg   <= ud_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            ovf_reg  <= ovf_next;
            neg_reg  <= neg_next;
            sat_reg  <= sat_next;
            zero_reg <= zero_next;
            res_reg  <= res_next;
        end
    end

    assign out_ctl = ctl_out_reg;
    assign norm_x  = res_reg[0];
    assign norm_y  = res_reg[1];

endmodule

// ===== design/ppd_distort.sv =====
`timescale 1ns / 1ps
// lens distortion and pixel mapping stages, ending in the output register
// depends on ppd_pkg

module ppd_distort
    import ppd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  ppd_cfg_t cfg,
    input  ppd_ctl_t in_ctl,
    input  word_t    norm_x,
    input  word_t    norm_y,
    output ppd_ctl_t out_ctl,
    output word_t    pixel_u,
    output word_t    pixel_v
);

    word_t fx, fy, cx, cy, k1, k2, p1, p2;

    assign fx = cfg.fx;
    assign fy = cfg.fy;
    assign cx = cfg.cx;
    assign cy = cfg.cy;
    assign k1 = cfg.k1;
    assign k2 = cfg.k2;
    assign p1 = cfg.p1;
    assign p2 = cfg.p2;

    // e1: squares and cross product
    logic signed [33:0] xx1_reg, yy1_reg, nxy1_reg;
    word_t              x1_reg, y1_reg;
    ppd_ctl_t           ctl1_reg;

    // e2: radius squared and tangential sums
    logic signed [34:0] r2_2_reg;
    logic signed [35:0] tx2_reg, ty2_reg;
    logic signed [33:0] nxy2_reg;
    word_t              x2_reg, y2_reg;
    ppd_ctl_t           ctl2_reg;

    // e3: coefficient products
    logic signed [69:0] r4_prod;
    logic signed [66:0] k1r2_prod;
    logic signed [65:0] p1nxy_prod, p2nxy_prod;
    logic signed [67:0] p2tx_prod, p1ty_prod;
    logic signed [39:0] r4_3_reg;
    logic signed [36:0] k1r2_3_reg;
    logic signed [35:0] p1nxy_3_reg, p2nxy_3_reg;
    logic signed [37:0] p2tx_3_reg, p1ty_3_reg;
    word_t              x3_reg, y3_reg;
    ppd_ctl_t           ctl3_reg;

    always_comb
    begin
        r4_prod    = r2_2_reg * r2_2_reg;
        k1r2_prod  = k1 * r2_2_reg;
        p1nxy_prod = p1 * nxy2_reg;
        p2nxy_prod = p2 * nxy2_reg;
        p2tx_prod  = p2 * tx2_reg;
        p1ty_prod  = p1 * ty2_reg;
    end

    // e4: radial factor and tangential offsets
    logic signed [71:0] k2r4_prod;
    logic signed [41:0] k2r4;
    logic signed [42:0] radial4_reg;
    logic signed [38:0] txp4_reg, typ4_reg;
    word_t              x4_reg, y4_reg;
    ppd_ctl_t           ctl4_reg;

    always_comb
    begin
        k2r4_prod = k2 * r4_3_reg;
        k2r4      = k2r4_prod[71:30];
    end

    // e5: distorted coordinates
    logic signed [74:0] xr_prod, yr_prod;
    logic signed [44:0] xr, yr;
    logic signed [45:0] xd5_reg, yd5_reg;
    ppd_ctl_t           ctl5_reg;

    always_comb
    begin
        xr_prod = x4_reg * radial4_reg;
        yr_prod = y4_reg * radial4_reg;
        xr      = xr_prod[74:30];
        yr      = yr_prod[74:30];
    end

    // e6: focal products split into two partial products each
    logic signed [23:0] xd_hi, yd_hi;
    logic signed [22:0] xd_lo, yd_lo;
    logic signed [55:0] phu6_reg, phv6_reg;
    logic signed [54:0] plu6_reg, plv6_reg;
    ppd_ctl_t           ctl6_reg;

    assign xd_hi = xd5_reg[45:22];
    assign yd_hi = yd5_reg[45:22];
    assign xd_lo = {1'b0, xd5_reg[21:0]};
    assign yd_lo = {1'b0, yd5_reg[21:0]};

    // e7: combine, add principal point, clamp
    logic signed [77:0] full_u, full_v;
    logic signed [47:0] fu, fv;
    logic signed [48:0] u_sum, v_sum;
    logic               u_ov, v_ov;
    word_t              u_next, v_next;
    ppd_ctl_t           ctl7_next, ctl7_reg;
    word_t              u7_reg, v7_reg;

    always_comb
    begin
        full_u = (78'(phu6_reg) <<< 22) + 78'(plu6_reg);
        full_v = (78'(phv6_reg) <<< 22) + 78'(plv6_reg);
        fu     = full_u[77:30];
        fv     = full_v[77:30];
        u_sum  = 49'(fu) + 49'(cx);
        v_sum  = 49'(fv) + 49'(cy);
        u_ov   = !((&u_sum[48:31]) || !(|u_sum[48:31]));
        v_ov   = !((&v_sum[48:31]) || !(|v_sum[48:31]));
        u_next = u_ov ? {u_sum[48], {31{~u_sum[48]}}} : u_sum[31:0];
        v_next = v_ov ? {v_sum[48], {31{~v_sum[48]}}} : v_sum[31:0];
        ctl7_next     = ctl6_reg;
        ctl7_next.sat = ctl6_reg.sat | u_ov | v_ov;
        // zero depth gives a clean result
        if (ctl6_reg.zero)
        begin
            u_next        = '0;
            v_next        = '0;
            ctl7_next.sat = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl7_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx1_reg  <= mul_q30(norm_x, norm_x);
            yy1_reg  <= mul_q30(norm_y, norm_y);
            nxy1_reg <= mul_q30(norm_x, norm_y);
            x1_reg   <= norm_x;
            y1_reg   <= norm_y;

            r2_2_reg <= 35'(xx1_reg) + 35'(yy1_reg);
            tx2_reg  <= 36'(xx1_reg) + 36'(yy1_reg) + (36'(xx1_reg) <<< 1);
            ty2_reg  <= 36'(xx1_reg) + 36'(yy1_reg) + (36'(yy1_reg) <<< 1);
            nxy2_reg <= nxy1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;

            r4_3_reg    <= r4_prod[69:30];
            k1r2_3_reg  <= k1r2_prod[66:30];
            p1nxy_3_reg <= p1nxy_prod[65:30];
            p2nxy_3_reg <= p2nxy_prod[65:30];
            p2tx_3_reg  <= p2tx_prod[67:30];
            p1ty_3_reg  <= p1ty_prod[67:30];
            x3_reg      <= x2_reg;
            y3_reg      <= y2_reg;

            radial4_reg <= 43'(ONE_Q30) + 43'(k1r2_3_reg) + 43'(k2r4);
            txp4_reg    <= (39'(p1nxy_3_reg) <<< 1) + 39'(p2tx_3_reg);
            typ4_reg    <= 39'(p1ty_3_reg) + (39'(p2nxy_3_reg) <<< 1);
            x4_reg      <= x3_reg;
            y4_reg      <= y3_reg;

            xd5_reg <= 46'(xr) + 46'(txp4_reg);
            yd5_reg <= 46'(yr) + 46'(typ4_reg);

            phu6_reg <= xd_hi * fx;
            plu6_reg <= xd_lo * fx;
            phv6_reg <= yd_hi * fy;
            plv6_reg <= yd_lo * fy;

            u7_reg <= u_next;
            v7_reg <= v_next;
        end
    end

    assign out_ctl = ctl7_reg;
    assign pixel_u = u7_reg;
    assign pixel_v = v7_reg;

endmodule

// ===== design/pinhole_projection_distortion_unit.sv =====
`timescale 1ns / 1ps
// Pinhole camera projection with radial and tangential lens distortion.
// Input stream (s_*): one transaction per observation, ten 32-bit fields packed
//   in s_tdata: quaternion (Q2.30), camera centre and world point (Q16.16).
// Output stream (m_*): one transaction per observation, pixel u and v in Q16.16
//   in m_tdata, depth-zero and saturation flags in m_tuser.
// Configuration channel (cfg_*): register index and 32-bit data, always ready;
//   indexes past the last register are dropped. Write only while the pipe is empty.
// Throughput: one observation per cycle, sustained while the output is not stalled.
// Pipeline: pose maths, then the perspective divide (two quotient bits a stage),
//   then distortion and pixel mapping, the last being the output register.
// Stall: the whole pipe holds while m_tvalid is high and m_tready low, and
//   s_tready follows it, so nothing is lost or repeated.
// Reset: asynchronous, clears all pipe valid bits and loads the default
//   intrinsics and lens coefficients; no clearing pass is needed.
// Depends on ppd_pkg, ppd_rotate, ppd_div and ppd_distort.

module pinhole_projection_distortion_unit
    import ppd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // rot_w, rot_x, rot_y, rot_z, centre_x, centre_y, centre_z,
    // world_x, world_y, world_z (32 bits each, lowest first)
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [319:0]         s_tdata,
    // pixel_u, pixel_v (32 bits each, lowest first)
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    // depth_zero, saturated (lowest first)
    output logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic en;
    word_t in_w [10];

    // configuration registers
    word_t    cfg_reg [NUM_CFG];
    ppd_cfg_t cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_CFG)))
        begin
            cfg_reg[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    assign cfg.fx = cfg_reg[CFG_FOCAL_X];
    assign cfg.fy = cfg_reg[CFG_FOCAL_Y];
    assign cfg.cx = cfg_reg[CFG_PRINC_X];
    assign cfg.cy = cfg_reg[CFG_PRINC_Y];
    assign cfg.k1 = cfg_reg[CFG_RADIAL_K1];
    assign cfg.k2 = cfg_reg[CFG_RADIAL_K2];
    assign cfg.p1 = cfg_reg[CFG_TANG_P1];
    assign cfg.p2 = cfg_reg[CFG_TANG_P2];

    // pipe advances unless a finished result is held back
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // unpack the input transaction
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            in_w[i] = s_tdata[32*i +: 32];
        end
    end

    ppd_ctl_t in_ctl, rot_ctl, div_ctl, out_ctl;
    logic signed [DATA_WIDTH-1:0] p_x, p_y, p_z;
    word_t norm_x, norm_y, pixel_u, pixel_v;

    assign in_ctl = '{valid: s_tvalid, sat: 1'b0, zero: 1'b0};

    ppd_rotate #(
        .DW (DATA_WIDTH)
    ) u_rotate (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_ctl   (in_ctl),
        .rot_w    (in_w[0]),
        .rot_x    (in_w[1]),
        .rot_y    (in_w[2]),
        .rot_z    (in_w[3]),
        .centre_x (in_w[4]),
        .centre_y (in_w[5]),
        .centre_z (in_w[6]),
        .world_x  (in_w[7]),
        .world_y  (in_w[8]),
        .world_z  (in_w[9]),
        .out_ctl  (rot_ctl),
        .p_x      (p_x),
        .p_y      (p_y),
        .p_z      (p_z)
    );

    ppd_div #(
        .DW (DATA_WIDTH)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (rot_ctl),
        .p_x     (p_x),
        .p_y     (p_y),
        .p_z     (p_z),
        .out_ctl (div_ctl),
        .norm_x  (norm_x),
        .norm_y  (norm_y)
    );

    ppd_distort u_distort (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .cfg     (cfg),
        .in_ctl  (div_ctl),
        .norm_x  (norm_x),
        .norm_y  (norm_y),
        .out_ctl (out_ctl),
        .pixel_u (pixel_u),
        .pixel_v (pixel_v)
    );

    // pack the output transaction
    assign m_tvalid = out_ctl.valid;
    assign m_tdata  = {pixel_v, pixel_u};
    assign m_tuser  = {out_ctl.sat, out_ctl.zero};

`ifndef SYNTHESIS
    // a zero-depth result carries no pixel and no saturation
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("zero-depth result not cleared");

    // a held result freezes the input side
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result presented during reset");
`endif

endmodule
